/* rtl/core/iatv_pkg.sv */
package iatv_pkg;

  // character codes of interest
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_F  = 8'h46;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_COLON    = 8'h3a;

  // ipv4 octet and dot rules
  localparam int unsigned OCTET_MAX   = 255;
  localparam int unsigned V4_DOTS     = 3;
  // ipv6 colon rule: count saturates at the first count over the limit
  localparam int unsigned COLON_W     = 4;
  localparam int unsigned COLON_SAT   = 8;

  typedef enum logic [1:0] {
    CLASS_INVALID = 2'd0,
    CLASS_IPV4    = 2'd1,
    CLASS_IPV6    = 2'd2,
    CLASS_DOMAIN  = 2'd3
  } addr_class_e;

  typedef enum logic [2:0] {
    DET_OK          = 3'd0,
    DET_OCTET_OVER  = 3'd1,
    DET_BAD_LENGTH  = 3'd2,
    DET_DOT_COUNT   = 3'd3,
    DET_COLON_COUNT = 3'd4
  } detail_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    addr_class_e address_class;
    logic        is_valid;
    detail_e     detail_code;
  } out_item_t;

endpackage

/* rtl/core/iatv_stream_if.sv */
interface iatv_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ip_address_text_validator.sv */
// result: out_o.valid rises as the result register takes the last character's verdict
// throughput: one character per cycle while no result waits; one input register, one result
//   register, the class tests, counters and octet accumulate sit between them
// reset: rst_ni clears the pipeline valid bits and all scan state; no clearing pass
// scan state also clears after each final character
module ip_address_text_validator #(
  parameter int unsigned V4_MAX_LENGTH = 15,
  parameter int unsigned V4_MIN_LENGTH = 7,
  parameter int unsigned V6_SCAN_LIMIT = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  iatv_stream_if.sink   in_i,
  iatv_stream_if.source out_o
);
  import iatv_pkg::*;

  localparam int unsigned V4_TOP = (V4_MAX_LENGTH > V4_MIN_LENGTH) ? V4_MAX_LENGTH
                                                                   : V4_MIN_LENGTH;
  localparam int unsigned L4W = $clog2(V4_TOP + 1);
  localparam int unsigned L6W = $clog2(V6_SCAN_LIMIT + 2);

  // input register
  logic     in_valid_q;
  in_item_t in_item_q;
  // result register
  logic      res_valid_q;
  out_item_t res_item_q;
  out_item_t res_item_d;

  // scan state
  logic           seen_digit_q, seen_digit_d;
  logic           seen_hex_q, seen_hex_d;
  logic           seen_dot_q, seen_dot_d;
  logic           seen_colon_q, seen_colon_d;
  logic           seen_other_q, seen_other_d;
  logic [L4W-1:0] v4_len_q, v4_len_d;
  logic [L4W-1:0] dot_cnt_q, dot_cnt_d;
  logic [7:0]     octet_q, octet_d;
  logic           octet_ovf_q, octet_ovf_d;
  logic [L6W-1:0] v6_len_q, v6_len_d;
  logic [COLON_W-1:0] colon_cnt_q, colon_cnt_d;

  logic        advance;
  logic        is_digit, is_hex, is_dot, is_colon;
  logic        scan4, scan6;
  logic [11:0] octet_ext;
  logic [11:0] octet_next;
  logic [7:0]  ch;

  // pipeline handshake
  assign advance     = in_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_item_q;

  // character classes
  assign ch       = in_item_q.character;
  assign is_digit = (ch >= CH_DIGIT_LO) && (ch <= CH_DIGIT_HI);
  assign is_hex   = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_F)) ||
                    ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_F));
  assign is_dot   = (ch == CH_DOT);
  assign is_colon = (ch == CH_COLON);

  // octet times ten plus digit
  assign octet_ext  = 12'(octet_q);
  assign octet_next = (octet_ext << 3) + (octet_ext << 1) + 12'(4'(ch - CH_DIGIT_LO));

  assign scan4 = !octet_ovf_q && (v4_len_q < L4W'(V4_MAX_LENGTH));
  assign scan6 = (v6_len_q <= L6W'(V6_SCAN_LIMIT));

  // next scan state
  always_comb begin
    seen_digit_d = seen_digit_q || is_digit;
    seen_hex_d   = seen_hex_q || is_hex;
    seen_dot_d   = seen_dot_q || is_dot;
    seen_colon_d = seen_colon_q || is_colon;
    seen_other_d = seen_other_q || !(is_digit || is_hex || is_dot || is_colon);

    v4_len_d    = v4_len_q;
    dot_cnt_d   = dot_cnt_q;
    octet_d     = octet_q;
    octet_ovf_d = octet_ovf_q;
    if (scan4) begin
      if (is_dot) begin
        dot_cnt_d = dot_cnt_q + 1'b1;
        octet_d   = '0;
      end else if (is_digit) begin
        if (octet_next > 12'(OCTET_MAX)) begin
          octet_ovf_d = 1'b1;
        end else begin
          octet_d = octet_next[7:0];
        end
      end
      v4_len_d = v4_len_q + 1'b1;
    end

    v6_len_d    = v6_len_q;
    colon_cnt_d = colon_cnt_q;
    if (scan6) begin
      if (is_colon && (colon_cnt_q < COLON_W'(COLON_SAT))) begin
        colon_cnt_d = colon_cnt_q + 1'b1;
      end
      v6_len_d = v6_len_q + 1'b1;
    end
  end

  // classification on the updated state
  always_comb begin
    res_item_d.address_class = CLASS_INVALID;
    res_item_d.is_valid      = 1'b0;
    res_item_d.detail_code   = DET_OK;
    priority if (seen_digit_d && seen_dot_d && !seen_colon_d && !seen_hex_d &&
                 !seen_other_d) begin
      res_item_d.address_class = CLASS_IPV4;
      priority if (octet_ovf_d) begin
        res_item_d.detail_code = DET_OCTET_OVER;
      end else if ((v4_len_d < L4W'(V4_MIN_LENGTH)) ||
                   (v4_len_d > L4W'(V4_MAX_LENGTH))) begin
        res_item_d.detail_code = DET_BAD_LENGTH;
      end else if (dot_cnt_d != L4W'(V4_DOTS)) begin
        res_item_d.detail_code = DET_DOT_COUNT;
      end else begin
        res_item_d.detail_code = DET_OK;
      end
      res_item_d.is_valid = (res_item_d.detail_code == DET_OK);
    end else if (seen_digit_d && seen_colon_d && seen_hex_d && !seen_other_d &&
                 !seen_dot_d) begin
      res_item_d.address_class = CLASS_IPV6;
      res_item_d.detail_code   = (colon_cnt_d >= COLON_W'(COLON_SAT)) ? DET_COLON_COUNT
                                                                       : DET_OK;
      res_item_d.is_valid      = (res_item_d.detail_code == DET_OK);
    end else if (!seen_colon_d) begin
      res_item_d.address_class = CLASS_DOMAIN;
      res_item_d.is_valid      = 1'b1;
    end else begin
      res_item_d.address_class = CLASS_INVALID;
    end
  end

  // control and scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      seen_digit_q <= 1'b0;
      seen_hex_q   <= 1'b0;
      seen_dot_q   <= 1'b0;
      seen_colon_q <= 1'b0;
      seen_other_q <= 1'b0;
      v4_len_q     <= '0;
      dot_cnt_q    <= '0;
      octet_q      <= '0;
      octet_ovf_q  <= 1'b0;
      v6_len_q     <= '0;
      colon_cnt_q  <= '0;
    end else begin
      in_valid_q  <= (in_i.valid && in_i.ready) || (in_valid_q && !advance);
      res_valid_q <= (res_valid_q && !out_o.ready) || (advance && in_item_q.last);
      if (advance) begin
        if (in_item_q.last) begin
          seen_digit_q <= 1'b0;
          seen_hex_q   <= 1'b0;
          seen_dot_q   <= 1'b0;
          seen_colon_q <= 1'b0;
          seen_other_q <= 1'b0;
          v4_len_q     <= '0;
          dot_cnt_q    <= '0;
          octet_q      <= '0;
          octet_ovf_q  <= 1'b0;
          v6_len_q     <= '0;
          colon_cnt_q  <= '0;
        end else begin
          seen_digit_q <= seen_digit_d;
          seen_hex_q   <= seen_hex_d;
          seen_dot_q   <= seen_dot_d;
          seen_colon_q <= seen_colon_d;
          seen_other_q <= seen_other_d;
          v4_len_q     <= v4_len_d;
          dot_cnt_q    <= dot_cnt_d;
          octet_q      <= octet_d;
          octet_ovf_q  <= octet_ovf_d;
          v6_len_q     <= v6_len_d;
          colon_cnt_q  <= colon_cnt_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.data;
    end
    if (advance && in_item_q.last) begin
      res_item_q <= res_item_d;
    end
  end

endmodule

/* bench/ip_address_text_validator_tb.sv */
`timescale 1ns / 100ps

module ip_address_text_validator_tb;
  import iatv_pkg::*;

  localparam int unsigned V4_MAX_LEN   = 15;
  localparam int unsigned V4_MIN_LEN   = 7;
  localparam int unsigned V6_SCAN_LIM  = 32;
  localparam int unsigned RANDOM_CHARS = 420;
  localparam int unsigned IDLE_PCT     = 13;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned CALM_CHARS   = 160;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned ROW_COUNT    = 17;

  typedef enum int unsigned {
    KIND_IPV4,
    KIND_IPV6,
    KIND_DOMAIN,
    KIND_NOISE,
    KIND_BROKEN
  } text_kind_e;

  // one directed string, with its verdict typed in where it is obvious
  typedef struct {
    string     text;
    bit        typed;
    out_item_t want;
  } text_row_t;

  // running scan of the string being received
  typedef struct {
    bit                 digit;
    bit                 hex_letter;
    bit                 dot;
    bit                 colon;
    bit                 other;
    logic [3:0]         v4_len;
    logic [3:0]         dots;
    logic [7:0]         octet;
    bit                 octet_over;
    logic [5:0]         v6_len;
    logic [COLON_W-1:0] colons;
  } scan_state_t;

  logic clk_i;
  logic rst_ni;

  iatv_stream_if #(.payload_t(in_item_t))  char_if ();
  iatv_stream_if #(.payload_t(out_item_t)) verdict_if ();

  ip_address_text_validator #(
    .V4_MAX_LENGTH(V4_MAX_LEN),
    .V4_MIN_LENGTH(V4_MIN_LEN),
    .V6_SCAN_LIMIT(V6_SCAN_LIM)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (char_if),
    .out_o (verdict_if)
  );

  scan_state_t scan;
  out_item_t   verdict_q[$];
  logic [7:0]  text_buf[$];
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned verdict_count = 0;
  int unsigned chars_sent = 0;
  int unsigned kind_count [5] = '{default: 0};

  text_row_t directed_rows [ROW_COUNT] = '{
    '{"1.2.3.4",           1'b1, '{CLASS_IPV4,    1'b1, DET_OK}},
    '{"255.255.255.255",   1'b1, '{CLASS_IPV4,    1'b1, DET_OK}},
    '{"256.1.1.1",         1'b1, '{CLASS_IPV4,    1'b0, DET_OCTET_OVER}},
    '{"1.2.3",             1'b1, '{CLASS_IPV4,    1'b0, DET_BAD_LENGTH}},
    '{"10.0.0.1.2",        1'b1, '{CLASS_IPV4,    1'b0, DET_DOT_COUNT}},
    '{"1.2.3.4.5.6.7.8.9", 1'b0, '0},
    '{"fe80::1",           1'b1, '{CLASS_IPV6,    1'b1, DET_OK}},
    '{"1:2:3:4:5:6:7:8:a", 1'b1, '{CLASS_IPV6,    1'b0, DET_COLON_COUNT}},
    '{"1:2",               1'b1, '{CLASS_INVALID, 1'b0, DET_OK}},
    '{"x:1",               1'b1, '{CLASS_INVALID, 1'b0, DET_OK}},
    '{"a.b-c",             1'b1, '{CLASS_DOMAIN,  1'b1, DET_OK}},
    '{"\200",              1'b1, '{CLASS_DOMAIN,  1'b1, DET_OK}},
    '{"\377\001",          1'b1, '{CLASS_DOMAIN,  1'b1, DET_OK}},
    '{"12",                1'b1, '{CLASS_DOMAIN,  1'b1, DET_OK}},
    '{"1.2.3.4a",          1'b0, '0},
    '{"999.9.9.99",        1'b0, '0},
    '{"0A:bC::9",          1'b0, '0}
  };

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached, %0d verdicts outstanding",
               CYCLE_LIMIT, verdict_q.size());
      $display("** ip_address_text_validator: FAILED **");
      $finish;
    end
  end

  // expected verdict for one character, returns 1 on the final character
  function automatic bit predict_verdict(input logic [7:0] ch, input bit is_last,
                                         output out_item_t v);
    bit          is_digit;
    bit          is_hex;
    bit          is_dot;
    bit          is_colon;
    int unsigned octet_next;
    is_digit = (ch >= CH_DIGIT_LO) && (ch <= CH_DIGIT_HI);
    is_hex   = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_F)) ||
               ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_F));
    is_dot   = (ch == CH_DOT);
    is_colon = (ch == CH_COLON);
    v = '{CLASS_INVALID, 1'b0, DET_OK};

    // character classes
    scan.digit      |= is_digit;
    scan.hex_letter |= is_hex;
    scan.dot        |= is_dot;
    scan.colon      |= is_colon;
    scan.other      |= !(is_digit || is_hex || is_dot || is_colon);

    // ipv4 scan, frozen after an octet overflow or the length cap
    if (!scan.octet_over && scan.v4_len < V4_MAX_LEN) begin
      if (is_dot) begin
        scan.dots++;
        scan.octet = '0;
      end else if (is_digit) begin
        octet_next = int'(scan.octet) * 10 + int'(ch - CH_DIGIT_LO);
        if (octet_next > OCTET_MAX) scan.octet_over = 1'b1;
        else scan.octet = octet_next[7:0];
      end
      scan.v4_len++;
    end

    // ipv6 colon count over the leading window only
    if (scan.v6_len <= V6_SCAN_LIM) begin
      if (is_colon && scan.colons < COLON_SAT) scan.colons++;
      scan.v6_len++;
    end

    if (!is_last) return 1'b0;

    // classify by priority
    if (scan.digit && scan.dot && !scan.colon && !scan.hex_letter && !scan.other) begin
      v.address_class = CLASS_IPV4;
      if (scan.octet_over) v.detail_code = DET_OCTET_OVER;
      else if (scan.v4_len < V4_MIN_LEN || scan.v4_len > V4_MAX_LEN)
        v.detail_code = DET_BAD_LENGTH;
      else if (scan.dots != V4_DOTS) v.detail_code = DET_DOT_COUNT;
      v.is_valid = (v.detail_code == DET_OK);
    end else if (scan.digit && scan.colon && scan.hex_letter && !scan.other && !scan.dot) begin
      v.address_class = CLASS_IPV6;
      if (scan.colons >= COLON_SAT) v.detail_code = DET_COLON_COUNT;
      v.is_valid = (v.detail_code == DET_OK);
    end else if (!scan.colon) begin
      v.address_class = CLASS_DOMAIN;
      v.is_valid      = 1'b1;
    end
    scan = '{default: '0};
    return 1'b1;
  endfunction

  // string builders, all append to text_buf
  function automatic void put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void put_ipv4(input int unsigned n_octets);
    int unsigned i;
    int unsigned pick;
    for (i = 0; i < n_octets; i++) begin
      if (i != 0) text_buf.push_back(CH_DOT);
      pick = $urandom_range(99);
      if (pick < 85) put_text($sformatf("%0d", $urandom_range(255)));
      else if (pick < 95) put_text($sformatf("%0d", $urandom_range(999, 256)));
      else put_text($sformatf("0%0d", $urandom_range(99)));
    end
  endfunction

  function automatic void put_ipv6();
    string       hex_set = "0123456789abcdefABCDEF";
    int unsigned groups;
    int unsigned g;
    groups = $urandom_range(10, 2);
    // occasionally a long lead-in so colons land past the scan window
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(40, 30)) text_buf.push_back(hex_set[$urandom_range(21)]);
    for (g = 0; g < groups; g++) begin
      if (g != 0) begin
        text_buf.push_back(CH_COLON);
        if ($urandom_range(7) == 0) text_buf.push_back(CH_COLON);
      end
      repeat ($urandom_range(4, 1)) text_buf.push_back(hex_set[$urandom_range(21)]);
    end
  endfunction

  function automatic void put_domain();
    string       label_set = "abcdefghijklmnopqrstuvwxyz0123456789-";
    int unsigned labels;
    int unsigned l;
    labels = $urandom_range(4, 1);
    for (l = 0; l < labels; l++) begin
      if (l != 0) text_buf.push_back(CH_DOT);
      repeat ($urandom_range(8, 1))
        text_buf.push_back(label_set[$urandom_range(label_set.len() - 1)]);
    end
  endfunction

  function automatic void put_noise();
    repeat ($urandom_range(12, 1)) text_buf.push_back(8'($urandom_range(255, 1)));
  endfunction

  // a well-formed address with one byte replaced, a cut tail or an extra dot
  function automatic void put_broken();
    int unsigned idx;
    int unsigned how;
    if ($urandom_range(1) != 0) put_ipv4(4);
    else put_ipv6();
    idx = $urandom_range(text_buf.size() - 1);
    how = $urandom_range(2);
    if (how == 0) text_buf[idx] = 8'($urandom_range(255, 1));
    else if (how == 1) text_buf = text_buf[0:idx];
    else text_buf.insert(idx, CH_DOT);
  endfunction

  // one character transfer, with an occasional gap in front
  task automatic send_char(input logic [7:0] ch, input bit is_last, input bit typed,
                           input out_item_t want);
    out_item_t predicted;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.data  <= '{character: ch, last: is_last};
    do @(posedge clk_i); while (!char_if.ready);
    chars_sent++;
    if (predict_verdict(ch, is_last, predicted))
      verdict_q.push_back(typed ? want : predicted);
  endtask

  task automatic send_text(input bit typed, input out_item_t want);
    int i;
    for (i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1, typed, want);
    text_buf.delete();
  endtask

  // receiver: random stalls, one long hold-off, calm stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_go && !hold_done) begin
        hold_left        <= HOLD_CYCLES;
        hold_done        <= 1'b1;
        verdict_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left        <= hold_left - 1;
        verdict_if.ready <= 1'b0;
      end else if (calm) begin
        verdict_if.ready <= 1'b1;
      end else begin
        verdict_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // verdict checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      verdict_count++;
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: unexpected verdict class %0d valid %0d detail %0d", $time,
                   verdict_if.data.address_class, verdict_if.data.is_valid,
                   verdict_if.data.detail_code);
      end else begin
        want = verdict_q.pop_front();
        if (verdict_if.data.address_class !== want.address_class ||
            verdict_if.data.is_valid !== want.is_valid ||
            verdict_if.data.detail_code !== want.detail_code) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: verdict %0d expected class %0d valid %0d detail %0d, got %0d %0d %0d",
                     $time, verdict_count, want.address_class, want.is_valid,
                     want.detail_code, verdict_if.data.address_class,
                     verdict_if.data.is_valid, verdict_if.data.detail_code);
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned row;
    int unsigned pick;
    int unsigned start;
    text_kind_e  kind;
    rst_ni           = 1'b0;
    char_if.valid    = 1'b0;
    char_if.data     = '0;
    verdict_if.ready = 1'b0;
    scan             = '{default: '0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings
    for (row = 0; row < ROW_COUNT; row++) begin
      put_text(directed_rows[row].text);
      send_text(directed_rows[row].typed, directed_rows[row].want);
    end

    // random strings, opening with a calm stretch under a long receiver hold
    calm    <= 1'b1;
    hold_go <= 1'b1;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      if (calm && chars_sent - start >= CALM_CHARS) calm <= 1'b0;
      pick = $urandom_range(99);
      if (pick < 35) kind = KIND_IPV4;
      else if (pick < 65) kind = KIND_IPV6;
      else if (pick < 80) kind = KIND_DOMAIN;
      else if (pick < 90) kind = KIND_NOISE;
      else kind = KIND_BROKEN;
      case (kind)
        KIND_IPV4: begin
          if ($urandom_range(4) == 0) put_ipv4($urandom_range(6, 3));
          else put_ipv4(4);
        end
        KIND_IPV6:   put_ipv6();
        KIND_DOMAIN: put_domain();
        KIND_NOISE:  put_noise();
        default:     put_broken();
      endcase
      kind_count[kind]++;
      send_text(1'b0, '0);
    end
    char_if.valid <= 1'b0;

    // drain
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d directed strings, random mix: ipv4 %0d, ipv6 %0d, domain %0d,",
             ROW_COUNT, kind_count[KIND_IPV4], kind_count[KIND_IPV6],
             kind_count[KIND_DOMAIN]);
    $display("  noise %0d, broken %0d; %0d characters transferred, %0d verdicts checked,",
             kind_count[KIND_NOISE], kind_count[KIND_BROKEN], chars_sent, verdict_count);
    $display("  %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("** ip_address_text_validator: PASSED **");
    end else begin
      $display("** ip_address_text_validator: FAILED **");
    end
    $finish;
  end

endmodule
